// File: design/icmp_fc_pkg.sv
// Shared types, field widths and codes for the ICMP flood classifier.
package icmp_fc_pkg;

	// Field widths
	localparam int unsigned SLOT_W  = 10;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned LEN_W   = 17;
	localparam int unsigned TYPE_W  = 8;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned TOTAL_W = 64;

	// Slot reduction: quotient estimate by a scaled reciprocal
	localparam int unsigned QUO_W       = 10;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP_W     = 21;

	// Request queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	typedef logic [SLOT_W-1:0]          slot_t;
	typedef logic [QUO_W-1:0]           quo_t;
	typedef logic [TIME_W-1:0]          time_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [TYPE_W-1:0]          icmp_type_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [TOTAL_W-1:0]         total_t;
	typedef logic [RECIP_W-1:0]         recip_t;
	typedef logic [SLOT_W+RECIP_W-1:0]  slot_prod_t;
	typedef logic [2*CNT_W-1:0]         wide_prod_t;
	typedef logic [1:0]                 decision_t;
	typedef logic [2:0]                 kind_t;
	typedef logic [QPTR_W-1:0]          qptr_t;
	typedef logic [QPTR_W:0]            qcount_t;

	// Verdict codes
	localparam decision_t DEC_ACCEPT = 2'd0;
	localparam decision_t DEC_DROP   = 2'd1;
	localparam decision_t DEC_LIMIT  = 2'd2;

	// Attack kinds
	localparam kind_t KIND_NONE     = 3'd0;
	localparam kind_t KIND_FLOOD    = 3'd1;
	localparam kind_t KIND_POD      = 3'd2;
	localparam kind_t KIND_FRAG     = 3'd3;
	localparam kind_t KIND_SMURF    = 3'd4;
	localparam kind_t KIND_REDIRECT = 3'd5;

	// ICMP types of interest
	localparam icmp_type_t TYPE_ECHO_REPLY = 8'd0;
	localparam icmp_type_t TYPE_REDIRECT   = 8'd5;
	localparam icmp_type_t TYPE_ECHO       = 8'd8;

	// Ping-of-death limits and broadcast match
	localparam len_t        MAX_PACKET_LEN  = 17'd65535;
	localparam len_t        MAX_PAYLOAD_LEN = 17'd65500;
	localparam logic [7:0]  BCAST_OCTET     = 8'hFF;

	// Threshold reset value and exact divide-by-ten constants
	localparam cnt_t        THRESHOLD_RESET = 32'd1000;
	localparam cnt_t        DIV10_RECIP     = 32'hCCCCCCCD;
	localparam int unsigned DIV10_SHIFT     = 35;

	// One classified request as it travels through the queue
	typedef struct packed {
		slot_t  slot;
		quo_t   quo;
		time_t  now;
		logic   icmp;
		logic   pod;
		logic   frag;
		logic   redirect;
		logic   smurf;
		logic   other_type;
	} item_t;

endpackage

// File: design/icmp_fc_front.sv
// Front end: accepts descriptors, derives the stateless checks and queues them.
module icmp_fc_front #(
	parameter int unsigned SOURCES = 1024
) (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  icmp_fc_pkg::slot_t          source_slot,
	input  icmp_fc_pkg::time_t          now_seconds,
	input  logic                        is_icmp,
	input  icmp_fc_pkg::len_t           packet_length,
	input  icmp_fc_pkg::len_t           payload_length,
	input  logic                        is_fragment,
	input  icmp_fc_pkg::icmp_type_t     icmp_type,
	input  logic                        dest_is_ipv4,
	input  logic [icmp_fc_pkg::ADDR_W-1:0] dest_address,
	input  logic                        busy,
	output logic                        push_valid,
	output icmp_fc_pkg::item_t          push_item,
	input  logic                        push_ready
);

	// floor(2^20 / SOURCES): the quotient estimate is low by at most one
	localparam icmp_fc_pkg::recip_t SLOT_RECIP =
		icmp_fc_pkg::recip_t'((1 << icmp_fc_pkg::RECIP_SHIFT) / SOURCES);

	icmp_fc_pkg::slot_prod_t slot_prod;

	// Handshake: hold off while the tables are being cleared
	assign in_ready   = push_ready && !busy;
	assign push_valid = in_valid && !busy;

	// Quotient estimate of slot / SOURCES
	assign slot_prod = icmp_fc_pkg::slot_prod_t'(source_slot) *
		icmp_fc_pkg::slot_prod_t'(SLOT_RECIP);

	// Stateless classification
	always_comb begin
		push_item.slot     = source_slot;
		push_item.quo      = slot_prod[icmp_fc_pkg::RECIP_SHIFT +: icmp_fc_pkg::QUO_W];
		push_item.now      = now_seconds;
		push_item.icmp     = is_icmp;
		push_item.pod      = (packet_length > icmp_fc_pkg::MAX_PACKET_LEN) ||
			(payload_length > icmp_fc_pkg::MAX_PAYLOAD_LEN);
		push_item.frag     = is_fragment;
		push_item.redirect = (icmp_type == icmp_fc_pkg::TYPE_REDIRECT);
		push_item.smurf    = (icmp_type == icmp_fc_pkg::TYPE_ECHO_REPLY) && dest_is_ipv4 &&
			((dest_address[7:0] == icmp_fc_pkg::BCAST_OCTET) || (dest_address == '1));
		push_item.other_type = (icmp_type != icmp_fc_pkg::TYPE_ECHO) &&
			(icmp_type != icmp_fc_pkg::TYPE_ECHO_REPLY);
	end

endmodule

// File: design/icmp_fc_queue.sv
// Short request queue that decouples the front end from the table stage.
module icmp_fc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  icmp_fc_pkg::item_t  push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output icmp_fc_pkg::item_t  pop_item
);

	icmp_fc_pkg::item_t   slots_q [icmp_fc_pkg::QUEUE_DEPTH];
	icmp_fc_pkg::qptr_t   wr_ptr_q;
	icmp_fc_pkg::qptr_t   rd_ptr_q;
	icmp_fc_pkg::qcount_t count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != icmp_fc_pkg::qcount_t'(icmp_fc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: design/icmp_fc_back.sv
// Back end: per-source window table, verdict, totals and output register.
module icmp_fc_back #(
	parameter int unsigned SOURCES = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  icmp_fc_pkg::cnt_t       flood_threshold,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  icmp_fc_pkg::item_t      pop_item,
	output logic                    busy,
	output logic                    out_valid,
	input  logic                    out_ready,
	output icmp_fc_pkg::decision_t  verdict,
	output icmp_fc_pkg::kind_t      attack_kind,
	output icmp_fc_pkg::total_t     icmp_total,
	output icmp_fc_pkg::total_t     drop_total
);

	localparam int unsigned IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int unsigned RED_W = icmp_fc_pkg::SLOT_W + 18;

	typedef logic [RED_W-1:0] red_t;
	typedef logic [IDX_W-1:0] idx_t;

	// Table memories, no reset: cleared by a sweep after reset
	icmp_fc_pkg::cnt_t  cnt_mem [SOURCES];
	icmp_fc_pkg::time_t win_mem [SOURCES];

	// Control state
	logic                 clr_busy_q;
	idx_t                 clr_idx_q;
	logic                 valid_s1;
	logic                 out_valid_q;
	icmp_fc_pkg::cnt_t    thr_q;
	icmp_fc_pkg::total_t  icmp_total_q;
	icmp_fc_pkg::total_t  drop_total_q;

	// Stage 1 payload
	icmp_fc_pkg::item_t   item_s1;
	idx_t                 idx_s1;
	icmp_fc_pkg::cnt_t    cnt_rd_s1;
	icmp_fc_pkg::time_t   win_rd_s1;
	logic                 fwd_hit_s1;
	icmp_fc_pkg::cnt_t    fwd_cnt_s1;
	icmp_fc_pkg::time_t   fwd_win_s1;

	// Output payload and derived threshold
	icmp_fc_pkg::decision_t verdict_q;
	icmp_fc_pkg::kind_t     kind_q;
	icmp_fc_pkg::cnt_t      thr_div10_q;

	red_t                  head_red;
	idx_t                  pop_idx;
	logic                  pop;
	logic                  adv_s1;
	logic                  wr_en;
	icmp_fc_pkg::wide_prod_t thr_prod;
	icmp_fc_pkg::cnt_t     cnt_cur;
	icmp_fc_pkg::time_t    win_cur;
	icmp_fc_pkg::cnt_t     cnt_inc;
	logic                  win_closed;
	logic                  flood;
	logic                  restart;
	icmp_fc_pkg::cnt_t     cnt_new;
	icmp_fc_pkg::time_t    win_new;
	icmp_fc_pkg::decision_t verdict_nx;
	icmp_fc_pkg::kind_t    kind_nx;
	icmp_fc_pkg::total_t   icmp_total_nx;
	icmp_fc_pkg::total_t   drop_total_nx;

	assign cfg_ready   = 1'b1;
	assign busy        = clr_busy_q;
	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign attack_kind = kind_q;
	assign icmp_total  = icmp_total_q;
	assign drop_total  = drop_total_q;

	// Flow control: stage 1 moves into the output register when it is free
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign pop_ready = !valid_s1 || adv_s1;
	assign pop       = pop_valid && pop_ready;
	assign wr_en     = adv_s1 && item_s1.icmp;

	// Slot modulo SOURCES: estimate is at most one low, so one correction
	assign head_red = red_t'(pop_item.slot) - red_t'(pop_item.quo) * red_t'(SOURCES);
	assign pop_idx  = (head_red >= red_t'(SOURCES)) ?
		idx_t'(head_red - red_t'(SOURCES)) : idx_t'(head_red);

	// Exact threshold / 10 by reciprocal multiply
	assign thr_prod = icmp_fc_pkg::wide_prod_t'(thr_q) *
		icmp_fc_pkg::wide_prod_t'(icmp_fc_pkg::DIV10_RECIP);

	// Window update and verdict for the item in stage 1
	always_comb begin
		cnt_cur    = fwd_hit_s1 ? fwd_cnt_s1 : cnt_rd_s1;
		win_cur    = fwd_hit_s1 ? fwd_win_s1 : win_rd_s1;
		cnt_inc    = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
		win_closed = (item_s1.now != win_cur);
		flood      = win_closed && (cnt_inc > thr_q);
		restart    = win_closed && !flood;
		cnt_new    = restart ? '0 : cnt_inc;
		win_new    = restart ? item_s1.now : win_cur;

		verdict_nx = icmp_fc_pkg::DEC_ACCEPT;
		kind_nx    = icmp_fc_pkg::KIND_NONE;
		if (item_s1.icmp) begin
			if (flood) begin
				verdict_nx = icmp_fc_pkg::DEC_DROP;
				kind_nx    = icmp_fc_pkg::KIND_FLOOD;
			end else if (item_s1.pod) begin
				verdict_nx = icmp_fc_pkg::DEC_DROP;
				kind_nx    = icmp_fc_pkg::KIND_POD;
			end else if (item_s1.frag) begin
				verdict_nx = icmp_fc_pkg::DEC_DROP;
				kind_nx    = icmp_fc_pkg::KIND_FRAG;
			end else if (item_s1.redirect) begin
				verdict_nx = icmp_fc_pkg::DEC_DROP;
				kind_nx    = icmp_fc_pkg::KIND_REDIRECT;
			end else if (item_s1.smurf) begin
				verdict_nx = icmp_fc_pkg::DEC_DROP;
				kind_nx    = icmp_fc_pkg::KIND_SMURF;
			end else if (item_s1.other_type && (cnt_new > thr_div10_q)) begin
				verdict_nx = icmp_fc_pkg::DEC_LIMIT;
			end
		end

		// Saturating totals
		icmp_total_nx = icmp_total_q;
		if (item_s1.icmp && (icmp_total_q != '1)) begin
			icmp_total_nx = icmp_total_q + 1'b1;
		end
		drop_total_nx = drop_total_q;
		if ((verdict_nx != icmp_fc_pkg::DEC_ACCEPT) && (drop_total_q != '1)) begin
			drop_total_nx = drop_total_q + 1'b1;
		end
	end

	// Table memories: clearing sweep, write-back, registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			cnt_mem[clr_idx_q] <= '0;
			win_mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			cnt_mem[idx_s1] <= cnt_new;
			win_mem[idx_s1] <= win_new;
		end
		if (pop) begin
			cnt_rd_s1 <= cnt_mem[pop_idx];
			win_rd_s1 <= win_mem[pop_idx];
		end
	end

	// Control state, threshold and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q   <= 1'b1;
			clr_idx_q    <= '0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			thr_q        <= icmp_fc_pkg::THRESHOLD_RESET;
			icmp_total_q <= '0;
			drop_total_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == idx_t'(SOURCES - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_valid) begin
				thr_q <= flood_threshold;
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q  <= 1'b1;
				icmp_total_q <= icmp_total_nx;
				drop_total_q <= drop_total_nx;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1 payload, same-slot forwarding and output payload
	always_ff @(posedge clk) begin
		thr_div10_q <= icmp_fc_pkg::cnt_t'(thr_prod >> icmp_fc_pkg::DIV10_SHIFT);
		if (pop) begin
			item_s1    <= pop_item;
			idx_s1     <= pop_idx;
			fwd_hit_s1 <= wr_en && (idx_s1 == pop_idx);
			fwd_cnt_s1 <= cnt_new;
			fwd_win_s1 <= win_new;
		end
		if (adv_s1) begin
			verdict_q <= verdict_nx;
			kind_q    <= kind_nx;
		end
	end

endmodule

// File: design/icmp_flood_packet_classifier_core.sv
// Top level of the ICMP flood packet classifier.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | source_slot .. dest_address
//  cfg      | cfg_valid / cfg_ready | flood_threshold
//  out      | out_valid / out_ready | verdict, attack_kind, icmp_total, drop_total
//
// One request per cycle while the output is not stalled; a result passes the queue
// entry, the registered table read in stage 1, then the output register.
// After reset the per-source table is swept clear; in_ready is low meanwhile,
// cfg writes are taken. A stalled output fills the four-entry queue before
// in_ready drops.
module icmp_flood_packet_classifier_core #(
	parameter int unsigned SOURCES = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [icmp_fc_pkg::CNT_W-1:0]  flood_threshold,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [icmp_fc_pkg::SLOT_W-1:0] source_slot,
	input  logic [icmp_fc_pkg::TIME_W-1:0] now_seconds,
	input  logic                           is_icmp,
	input  logic [icmp_fc_pkg::LEN_W-1:0]  packet_length,
	input  logic [icmp_fc_pkg::LEN_W-1:0]  payload_length,
	input  logic                           is_fragment,
	input  logic [icmp_fc_pkg::TYPE_W-1:0] icmp_type,
	input  logic                           dest_is_ipv4,
	input  logic [icmp_fc_pkg::ADDR_W-1:0] dest_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     verdict,
	output logic [2:0]                     attack_kind,
	output logic [icmp_fc_pkg::TOTAL_W-1:0] icmp_total,
	output logic [icmp_fc_pkg::TOTAL_W-1:0] drop_total
);

	logic               busy;
	logic               push_valid;
	logic               push_ready;
	icmp_fc_pkg::item_t push_item;
	logic               pop_valid;
	logic               pop_ready;
	icmp_fc_pkg::item_t pop_item;

	// Classify and enqueue
	icmp_fc_front #(
		.SOURCES(SOURCES)
	) u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.source_slot    (source_slot),
		.now_seconds    (now_seconds),
		.is_icmp        (is_icmp),
		.packet_length  (packet_length),
		.payload_length (payload_length),
		.is_fragment    (is_fragment),
		.icmp_type      (icmp_type),
		.dest_is_ipv4   (dest_is_ipv4),
		.dest_address   (dest_address),
		.busy           (busy),
		.push_valid     (push_valid),
		.push_item      (push_item),
		.push_ready     (push_ready)
	);

	// Decoupling queue
	icmp_fc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Table update and result
	icmp_fc_back #(
		.SOURCES(SOURCES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.flood_threshold (flood_threshold),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_item        (pop_item),
		.busy            (busy),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.attack_kind     (attack_kind),
		.icmp_total      (icmp_total),
		.drop_total      (drop_total)
	);

endmodule

// File: tb/icmp_fc_verdict_checker.sv
// Checker for the ICMP flood classifier: predicts each verdict and compares the results.
`timescale 1ns / 100ps
module icmp_fc_verdict_checker #(
	parameter int unsigned SOURCES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [icmp_fc_pkg::CNT_W-1:0]     flood_threshold,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [icmp_fc_pkg::SLOT_W-1:0]    source_slot,
	input  logic [icmp_fc_pkg::TIME_W-1:0]    now_seconds,
	input  logic                              is_icmp,
	input  logic [icmp_fc_pkg::LEN_W-1:0]     packet_length,
	input  logic [icmp_fc_pkg::LEN_W-1:0]     payload_length,
	input  logic                              is_fragment,
	input  logic [icmp_fc_pkg::TYPE_W-1:0]    icmp_type,
	input  logic                              dest_is_ipv4,
	input  logic [icmp_fc_pkg::ADDR_W-1:0]    dest_address,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [1:0]                        verdict,
	input  logic [2:0]                        attack_kind,
	input  logic [icmp_fc_pkg::TOTAL_W-1:0]   icmp_total,
	input  logic [icmp_fc_pkg::TOTAL_W-1:0]   drop_total,
	output int                                fail_count,
	output int                                pending
);

	typedef struct packed {
		icmp_fc_pkg::decision_t verdict;
		icmp_fc_pkg::kind_t     kind;
		icmp_fc_pkg::total_t    icmp;
		icmp_fc_pkg::total_t    drops;
	} outcome_t;

	// Mirror of the classifier state
	icmp_fc_pkg::cnt_t   threshold_now;
	icmp_fc_pkg::cnt_t   window_count [SOURCES];
	icmp_fc_pkg::time_t  window_start [SOURCES];
	icmp_fc_pkg::total_t icmp_seen;
	icmp_fc_pkg::total_t drops_seen;

	outcome_t verdicts_due[$];
	outcome_t due_now;
	int       mismatches;

	// Work out the verdict of one request and advance the mirrored state
	function automatic outcome_t classify_packet(icmp_fc_pkg::slot_t s,
			icmp_fc_pkg::time_t now, logic icmp, icmp_fc_pkg::len_t plen,
			icmp_fc_pkg::len_t ylen, logic frag, icmp_fc_pkg::icmp_type_t ty, logic v4,
			logic [icmp_fc_pkg::ADDR_W-1:0] dst);
		outcome_t               o;
		icmp_fc_pkg::decision_t v;
		icmp_fc_pkg::kind_t     k;
		v = icmp_fc_pkg::DEC_ACCEPT;
		k = icmp_fc_pkg::KIND_NONE;
		// slot is 10 bits and SOURCES is 1024, so the modulo is the identity
		if (icmp) begin
			if (icmp_seen != '1)
				icmp_seen++;
			if (window_count[s] != '1)
				window_count[s]++;
			// window closed: flood keeps the source blocked, else the window restarts
			if (now != window_start[s]) begin
				if (window_count[s] > threshold_now) begin
					v = icmp_fc_pkg::DEC_DROP;
					k = icmp_fc_pkg::KIND_FLOOD;
				end else begin
					window_count[s] = '0;
					window_start[s] = now;
				end
			end
			if (v == icmp_fc_pkg::DEC_ACCEPT) begin
				if (plen > icmp_fc_pkg::MAX_PACKET_LEN ||
						ylen > icmp_fc_pkg::MAX_PAYLOAD_LEN) begin
					v = icmp_fc_pkg::DEC_DROP;
					k = icmp_fc_pkg::KIND_POD;
				end else if (frag) begin
					v = icmp_fc_pkg::DEC_DROP;
					k = icmp_fc_pkg::KIND_FRAG;
				end else if (ty == icmp_fc_pkg::TYPE_REDIRECT) begin
					v = icmp_fc_pkg::DEC_DROP;
					k = icmp_fc_pkg::KIND_REDIRECT;
				end else if (ty == icmp_fc_pkg::TYPE_ECHO_REPLY && v4 &&
						(dst[7:0] == icmp_fc_pkg::BCAST_OCTET || dst == '1)) begin
					v = icmp_fc_pkg::DEC_DROP;
					k = icmp_fc_pkg::KIND_SMURF;
				end else if (ty != icmp_fc_pkg::TYPE_ECHO &&
						ty != icmp_fc_pkg::TYPE_ECHO_REPLY &&
						window_count[s] > threshold_now / 32'd10) begin
					v = icmp_fc_pkg::DEC_LIMIT;
				end
			end
			if (v != icmp_fc_pkg::DEC_ACCEPT && drops_seen != '1)
				drops_seen++;
		end
		o.verdict = v;
		o.kind    = k;
		o.icmp    = icmp_seen;
		o.drops   = drops_seen;
		return o;
	endfunction

	// Watch the three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_now = icmp_fc_pkg::THRESHOLD_RESET;
			for (int i = 0; i < SOURCES; i++) begin
				window_count[i] = '0;
				window_start[i] = '0;
			end
			icmp_seen  = '0;
			drops_seen = '0;
			verdicts_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				threshold_now = flood_threshold;

			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result with no request waiting");
					mismatches++;
				end else begin
					due_now = verdicts_due.pop_front();
					if (verdict !== due_now.verdict) begin
						$error("verdict: expected %0d, got %0d", due_now.verdict, verdict);
						mismatches++;
					end
					if (attack_kind !== due_now.kind) begin
						$error("attack_kind: expected %0d, got %0d", due_now.kind, attack_kind);
						mismatches++;
					end
					if (icmp_total !== due_now.icmp) begin
						$error("icmp_total: expected %0d, got %0d", due_now.icmp, icmp_total);
						mismatches++;
					end
					if (drop_total !== due_now.drops) begin
						$error("drop_total: expected %0d, got %0d", due_now.drops, drop_total);
						mismatches++;
					end
				end
			end

			if (in_valid && in_ready)
				verdicts_due.push_back(classify_packet(source_slot, now_seconds, is_icmp,
					packet_length, payload_length, is_fragment, icmp_type, dest_is_ipv4,
					dest_address));
		end
		fail_count <= mismatches;
		pending    <= verdicts_due.size();
	end

endmodule

// File: tb/icmp_flood_packet_classifier_core_tb.sv
// Testbench top for the ICMP flood classifier: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps
module icmp_flood_packet_classifier_core_tb;

	localparam int unsigned SOURCES      = 1024;
	localparam int          STALL_LIMIT  = 6000;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          PHASE_ITEMS  = 200;
	localparam int          PHASES       = 9;

	typedef struct {
		icmp_fc_pkg::slot_t             slot;
		icmp_fc_pkg::time_t             now;
		logic                           icmp;
		icmp_fc_pkg::len_t              plen;
		icmp_fc_pkg::len_t              ylen;
		logic                           frag;
		icmp_fc_pkg::icmp_type_t        ty;
		logic                           v4;
		logic [icmp_fc_pkg::ADDR_W-1:0] dst;
	} desc_t;

	logic                                clk;
	logic                                arst_n          = 1'b0;
	logic                                cfg_valid       = 1'b0;
	logic                                cfg_ready;
	logic [icmp_fc_pkg::CNT_W-1:0]       flood_threshold = '0;
	logic                                in_valid        = 1'b0;
	logic                                in_ready;
	logic [icmp_fc_pkg::SLOT_W-1:0]      source_slot     = '0;
	logic [icmp_fc_pkg::TIME_W-1:0]      now_seconds     = '0;
	logic                                is_icmp         = 1'b0;
	logic [icmp_fc_pkg::LEN_W-1:0]       packet_length   = '0;
	logic [icmp_fc_pkg::LEN_W-1:0]       payload_length  = '0;
	logic                                is_fragment     = 1'b0;
	logic [icmp_fc_pkg::TYPE_W-1:0]      icmp_type       = '0;
	logic                                dest_is_ipv4    = 1'b0;
	logic [icmp_fc_pkg::ADDR_W-1:0]      dest_address    = '0;
	logic                                out_valid;
	logic                                out_ready       = 1'b0;
	logic [1:0]                          verdict;
	logic [2:0]                          attack_kind;
	logic [icmp_fc_pkg::TOTAL_W-1:0]     icmp_total;
	logic [icmp_fc_pkg::TOTAL_W-1:0]     drop_total;

	int                 fail_count;
	int                 pending;
	int                 quiet_cycles = 0;
	logic               calm         = 1'b0;
	icmp_fc_pkg::slot_t hot_slot     = '0;
	icmp_fc_pkg::time_t wall_time    = 32'd50;

	icmp_flood_packet_classifier_core #(.SOURCES(SOURCES)) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.flood_threshold (flood_threshold),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.source_slot     (source_slot),
		.now_seconds     (now_seconds),
		.is_icmp         (is_icmp),
		.packet_length   (packet_length),
		.payload_length  (payload_length),
		.is_fragment     (is_fragment),
		.icmp_type       (icmp_type),
		.dest_is_ipv4    (dest_is_ipv4),
		.dest_address    (dest_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.attack_kind     (attack_kind),
		.icmp_total      (icmp_total),
		.drop_total      (drop_total)
	);

	icmp_fc_verdict_checker #(.SOURCES(SOURCES)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.flood_threshold (flood_threshold),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.source_slot     (source_slot),
		.now_seconds     (now_seconds),
		.is_icmp         (is_icmp),
		.packet_length   (packet_length),
		.payload_length  (payload_length),
		.is_fragment     (is_fragment),
		.icmp_type       (icmp_type),
		.dest_is_ipv4    (dest_is_ipv4),
		.dest_address    (dest_address),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.attack_kind     (attack_kind),
		.icmp_total      (icmp_total),
		.drop_total      (drop_total),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Result side back-pressure
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 19);

	// Watchdog on cycles with no accepted request, result or threshold write
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("icmp_flood_packet_classifier_core_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic desc_t make_packet(icmp_fc_pkg::slot_t s, icmp_fc_pkg::time_t now,
			logic icmp, icmp_fc_pkg::len_t plen, icmp_fc_pkg::len_t ylen, logic frag,
			icmp_fc_pkg::icmp_type_t ty, logic v4, logic [icmp_fc_pkg::ADDR_W-1:0] dst);
		desc_t p;
		p.slot = s;
		p.now  = now;
		p.icmp = icmp;
		p.plen = plen;
		p.ylen = ylen;
		p.frag = frag;
		p.ty   = ty;
		p.v4   = v4;
		p.dst  = dst;
		return p;
	endfunction

	// Mostly well-formed traffic on a few busy sources with a slowly ticking clock
	function automatic desc_t random_packet();
		desc_t       p;
		int unsigned r;
		r = $urandom_range(999);
		if (r < 30)
			wall_time = wall_time + 1;
		else if (r < 34)
			wall_time = $urandom();
		else if (r < 36)
			wall_time = 32'hFFFF_FFFF - $urandom_range(3);
		else if (r < 38)
			wall_time = wall_time + $urandom_range(2, 5);
		p.now = ($urandom_range(99) < 2) ? icmp_fc_pkg::time_t'($urandom()) : wall_time;

		if ($urandom_range(99) == 0)
			hot_slot = icmp_fc_pkg::slot_t'($urandom_range(SOURCES - 1));
		r = $urandom_range(99);
		if (r < 45)
			p.slot = hot_slot;
		else if (r < 85)
			p.slot = {hot_slot[icmp_fc_pkg::SLOT_W-1:3], 3'($urandom_range(7))};
		else
			p.slot = icmp_fc_pkg::slot_t'($urandom_range(SOURCES - 1));

		p.icmp = $urandom_range(99) < 90;

		r = $urandom_range(99);
		if (r < 90)      p.plen = icmp_fc_pkg::len_t'($urandom_range(1500));
		else if (r < 92) p.plen = icmp_fc_pkg::MAX_PACKET_LEN;
		else if (r < 94) p.plen = icmp_fc_pkg::MAX_PACKET_LEN + 1'b1;
		else if (r < 95) p.plen = '1;
		else             p.plen = icmp_fc_pkg::len_t'($urandom_range(131071));

		r = $urandom_range(99);
		if (r < 90)      p.ylen = icmp_fc_pkg::len_t'($urandom_range(1472));
		else if (r < 92) p.ylen = icmp_fc_pkg::MAX_PAYLOAD_LEN;
		else if (r < 94) p.ylen = icmp_fc_pkg::MAX_PAYLOAD_LEN + 1'b1;
		else if (r < 95) p.ylen = '1;
		else             p.ylen = icmp_fc_pkg::len_t'($urandom_range(131071));

		p.frag = $urandom_range(99) < 7;

		r = $urandom_range(99);
		if (r < 35)      p.ty = icmp_fc_pkg::TYPE_ECHO;
		else if (r < 65) p.ty = icmp_fc_pkg::TYPE_ECHO_REPLY;
		else if (r < 70) p.ty = icmp_fc_pkg::TYPE_REDIRECT;
		else if (r < 80) p.ty = 8'd3;
		else if (r < 88) p.ty = 8'd11;
		else             p.ty = icmp_fc_pkg::icmp_type_t'($urandom_range(255));

		p.v4  = $urandom_range(99) < 85;
		p.dst = $urandom();
		r = $urandom_range(99);
		if (r < 15)
			p.dst[7:0] = icmp_fc_pkg::BCAST_OCTET;
		else if (r < 20)
			p.dst = '1;
		return p;
	endfunction

	// Offer one request and hold it until taken; valid stays up across back-to-back requests
	task automatic send_packet(input desc_t p);
		if (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 19)
				@(posedge clk);
		end
		in_valid       <= 1'b1;
		source_slot    <= p.slot;
		now_seconds    <= p.now;
		is_icmp        <= p.icmp;
		packet_length  <= p.plen;
		payload_length <= p.ylen;
		is_fragment    <= p.frag;
		icmp_type      <= p.ty;
		dest_is_ipv4   <= p.v4;
		dest_address   <= p.dst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop requests, let all results drain
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Threshold write, only with the block idle
	task automatic write_threshold(input icmp_fc_pkg::cnt_t value);
		drain_results();
		cfg_valid       <= 1'b1;
		flood_threshold <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		icmp_fc_pkg::cnt_t levels [PHASES];
		levels = '{32'd0, 32'd25, 32'd9, 32'd10, 32'hFFFF_FFFF, 32'd3, 32'd12,
			icmp_fc_pkg::cnt_t'($urandom_range(1, 60)), icmp_fc_pkg::THRESHOLD_RESET};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write during the table sweep
		write_threshold(icmp_fc_pkg::THRESHOLD_RESET);

		// Directed: field extremes and each stateless drop reason
		send_packet(make_packet(10'd1023, '1, 1'b0, '1, '1, 1'b1, 8'd255, 1'b1, '1));
		send_packet(make_packet(10'd0, 32'd0, 1'b1, 17'd0, 17'd0, 1'b0,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'd0));
		send_packet(make_packet(10'd1, 32'd0, 1'b1, icmp_fc_pkg::MAX_PACKET_LEN + 1'b1,
			17'd8, 1'b0, icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'h0A00_0001));
		send_packet(make_packet(10'd1, 32'd0, 1'b1, icmp_fc_pkg::MAX_PACKET_LEN,
			icmp_fc_pkg::MAX_PAYLOAD_LEN, 1'b0, icmp_fc_pkg::TYPE_ECHO, 1'b1,
			32'h0A00_0001));
		send_packet(make_packet(10'd1, 32'd0, 1'b1, 17'd100,
			icmp_fc_pkg::MAX_PAYLOAD_LEN + 1'b1, 1'b0, icmp_fc_pkg::TYPE_ECHO, 1'b1,
			32'h0A00_0001));
		send_packet(make_packet(10'd1, 32'd0, 1'b1, '1, '1, 1'b0, icmp_fc_pkg::TYPE_ECHO,
			1'b1, 32'd0));
		send_packet(make_packet(10'd2, 32'd0, 1'b1, 17'd84, 17'd56, 1'b1,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'hC0A8_0001));
		send_packet(make_packet(10'd2, 32'd0, 1'b1, 17'd84, 17'd56, 1'b0,
			icmp_fc_pkg::TYPE_REDIRECT, 1'b1, 32'hC0A8_0001));
		send_packet(make_packet(10'd3, 32'd0, 1'b1, 17'd84, 17'd56, 1'b0,
			icmp_fc_pkg::TYPE_ECHO_REPLY, 1'b1, 32'hC0A8_01FF));
		send_packet(make_packet(10'd3, 32'd0, 1'b1, 17'd84, 17'd56, 1'b0,
			icmp_fc_pkg::TYPE_ECHO_REPLY, 1'b1, '1));
		// broadcast reply without IPv4, and echo request to broadcast: both pass
		send_packet(make_packet(10'd3, 32'd0, 1'b1, 17'd84, 17'd56, 1'b0,
			icmp_fc_pkg::TYPE_ECHO_REPLY, 1'b0, '1));
		send_packet(make_packet(10'd3, 32'd0, 1'b1, 17'd84, 17'd56, 1'b0,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, '1));
		send_packet(make_packet(10'd4, 32'd0, 1'b1, 17'd60, 17'd32, 1'b0, 8'd3, 1'b1,
			32'h5555_AAAA));
		// window closes on slot 0 and restarts
		send_packet(make_packet(10'd0, 32'd5, 1'b1, 17'd60, 17'd32, 1'b0, 8'd255, 1'b1,
			32'hAAAA_5555));

		// Directed with a low threshold: window restart, rate limit, sticky flood
		write_threshold(32'd2);
		send_packet(make_packet(10'd7, 32'd100, 1'b1, 17'd64, 17'd36, 1'b0,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'h0101_0101));
		send_packet(make_packet(10'd7, 32'd100, 1'b1, 17'd64, 17'd36, 1'b0,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'h0101_0101));
		send_packet(make_packet(10'd7, 32'd100, 1'b1, 17'd64, 17'd36, 1'b0,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'h0101_0101));
		send_packet(make_packet(10'd7, 32'd100, 1'b1, 17'd64, 17'd36, 1'b0, 8'd11, 1'b1,
			32'h0101_0101));
		send_packet(make_packet(10'd7, 32'd101, 1'b1, 17'd64, 17'd36, 1'b0,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'h0101_0101));
		send_packet(make_packet(10'd7, 32'd102, 1'b1, 17'd64, 17'd36, 1'b0,
			icmp_fc_pkg::TYPE_ECHO, 1'b1, 32'h0101_0101));

		// Random phases, one threshold each; one phase runs without idling
		for (int ph = 0; ph < PHASES; ph++) begin
			write_threshold(levels[ph]);
			calm <= (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_packet(random_packet());
		end
		calm <= 1'b0;

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("icmp_flood_packet_classifier_core_tb: done, clean");
		else
			$display("icmp_flood_packet_classifier_core_tb: done, errors");
		$finish;
	end

endmodule
